@@ design/kmp_pkg.sv @@
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int CHR_W               = 21;
    localparam int POS_W               = 32;
    localparam int OP_W                = 2;
    localparam int IN_DATA_W           = 24;
    localparam int OUT_DATA_W          = 64;
    localparam int DEFAULT_MAX_PATTERN = 64;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } op_t;

    typedef enum logic {
        REG_IGNORE_CASE = 1'b0,
        REG_WHOLE_WORD  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic             clear;
        logic             step;
        logic [CHR_W-1:0] chr;
    } cell_ctrl_t;

    function automatic logic [CHR_W-1:0] fold(input logic [CHR_W-1:0] c);
        logic [CHR_W-1:0] r;
        r = c;
        if (c inside {[21'h41 : 21'h5A]})
        begin
            r = c + 21'h20;
        end
        return r;
    endfunction

    function automatic logic is_word(input logic [CHR_W-1:0] c);
        return (c == 21'h5F) || (c >= 21'h80) || (c inside {[21'h30 : 21'h39]})
            || (c inside {[21'h41 : 21'h5A]}) || (c inside {[21'h61 : 21'h7A]});
    endfunction

endpackage

@@ design/kmp_pattern_search.sv @@
`timescale 1ns / 1ps

// Streaming pattern matcher. Load a pattern with a start item followed by one
// append item per character, then stream text items and close with an end
// item. Items are handled without a busy state: a row of cells, one per
// pattern character, compares the incoming character against all pattern
// positions at once and shifts partial-match flags one cell along per text
// item, so the sustained rate is one item per clock unless the output stalls. A match is reported
// when the item after it arrives (next text character or end of text), since
// the whole-word check needs the follower. Input stalls only while a result
// sits in the output register and the sink is not ready.

module kmp_pattern_search #(
    parameter int MAX_PATTERN = kmp_pkg::DEFAULT_MAX_PATTERN
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic                           cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kmp_pkg::IN_DATA_W-1:0]  s_tdata,   // chr[20:0], zero pad
    input  logic [kmp_pkg::OP_W-1:0]       s_tuser,   // op[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kmp_pkg::OUT_DATA_W-1:0] m_tdata    // start_pos[31:0], end_pos[63:32]
);

    localparam int LENW = $clog2(MAX_PATTERN + 1);
    localparam int LW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic                          ignore_case_reg;
    logic                          whole_word_reg;
    logic [LENW-1:0]               len_reg;
    logic [LENW-1:0]               len_next;
    logic [kmp_pkg::POS_W-1:0]     pos_reg;
    logic [kmp_pkg::POS_W-1:0]     pos_next;
    logic                          last_word_reg;
    logic                          last_word_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [kmp_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic                          in_fire;
    kmp_pkg::op_t                  op;
    logic [kmp_pkg::CHR_W-1:0]     chr;
    logic [kmp_pkg::CHR_W-1:0]     fc;
    logic                          next_word;
    logic                          pending;
    logic                          prev_word;
    logic                          emit;
    logic [LW-1:0]                 idx;
    kmp_pkg::cell_ctrl_t           ctrl;
    logic [MAX_PATTERN-1:0]        match_vec;
    logic [MAX_PATTERN-1:0]        word_vec;
    logic [MAX_PATTERN-1:0]        load_vec;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign op        = kmp_pkg::op_t'(s_tuser);
    assign chr       = s_tdata[kmp_pkg::CHR_W-1:0];
    assign fc        = ignore_case_reg ? kmp_pkg::fold(chr) : chr;
    assign next_word = (op == kmp_pkg::OP_TEXT) && kmp_pkg::is_word(chr);
    assign idx       = LW'(len_reg - LENW'(1));
    assign pending   = (len_reg != '0) && match_vec[idx];
    assign prev_word = word_vec[idx];
    assign emit      = in_fire && pending
                       && (op == kmp_pkg::OP_TEXT || op == kmp_pkg::OP_END)
                       && !(whole_word_reg && (prev_word || next_word));

    assign ctrl.clear = in_fire && (op != kmp_pkg::OP_TEXT);
    assign ctrl.step  = in_fire && (op == kmp_pkg::OP_TEXT) && (len_reg != '0);
    assign ctrl.chr   = fc;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            assign load_vec[gi] = in_fire && (op == kmp_pkg::OP_APPEND)
                                  && (len_reg == LENW'(gi));
            if (gi == 0)
            begin : g_head
                kmp_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .load       (load_vec[gi]),
                    .prev_match (1'b1),
                    .prev_word  (last_word_reg),
                    .match      (match_vec[gi]),
                    .word       (word_vec[gi])
                );
            end
            else
            begin : g_body
                kmp_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .load       (load_vec[gi]),
                    .prev_match (match_vec[gi-1]),
                    .prev_word  (word_vec[gi-1]),
                    .match      (match_vec[gi]),
                    .word       (word_vec[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        len_next       = len_reg;
        pos_next       = pos_reg;
        last_word_next = last_word_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        if (in_fire)
        begin
            case (op)
                kmp_pkg::OP_START:
                begin
                    len_next       = '0;
                    pos_next       = '0;
                    last_word_next = 1'b0;
                end
                kmp_pkg::OP_APPEND:
                begin
                    if (len_reg < LENW'(MAX_PATTERN))
                    begin
                        len_next = len_reg + LENW'(1);
                    end
                    pos_next       = '0;
                    last_word_next = 1'b0;
                end
                kmp_pkg::OP_TEXT:
                begin
                    pos_next       = pos_reg + 32'd1;
                    last_word_next = kmp_pkg::is_word(chr);
                end
                default:
                begin
                    pos_next       = '0;
                    last_word_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_case_reg <= 1'b0;
            whole_word_reg  <= 1'b0;
            len_reg         <= '0;
            pos_reg         <= '0;
            last_word_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (kmp_pkg::reg_idx_t'(cfg_index) == kmp_pkg::REG_IGNORE_CASE)
                begin
                    ignore_case_reg <= cfg_data;
                end
                else
                begin
                    whole_word_reg <= cfg_data;
                end
            end
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            last_word_reg <= last_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= {pos_reg - 32'd1, pos_reg - kmp_pkg::POS_W'(len_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LENW'(MAX_PATTERN))
        else $error("pattern length out of range");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && op == kmp_pkg::OP_START |=> len_reg == '0 && pos_reg == '0)
        else $error("start did not clear state");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && op == kmp_pkg::OP_END |=> pos_reg == '0 && match_vec == '0)
        else $error("end of text did not clear text state");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_fire && pending
            && (op == kmp_pkg::OP_TEXT || op == kmp_pkg::OP_END)))
        else $error("result without a pending match");

endmodule

@@ design/kmp_cell.sv @@
`timescale 1ns / 1ps

module kmp_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  kmp_pkg::cell_ctrl_t ctrl,
    input  logic               load,
    input  logic               prev_match,
    input  logic               prev_word,
    output logic               match,
    output logic               word
);

    logic [kmp_pkg::CHR_W-1:0] chr_reg;
    logic                      match_reg;
    logic                      match_next;
    logic                      word_reg;
    logic                      word_next;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chr_reg <= ctrl.chr;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        word_next  = word_reg;
        if (ctrl.clear)
        begin
            match_next = 1'b0;
            word_next  = 1'b0;
        end
        else if (ctrl.step)
        begin
            match_next = prev_match && (chr_reg == ctrl.chr);
            word_next  = prev_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            word_reg  <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            word_reg  <= word_next;
        end
    end

    assign match = match_reg;
    assign word  = word_reg;

endmodule
